// File: hdl/idte_pkg.sv
// Package for the ISO date-time to epoch converter.
// Holds shared types, character codes and arithmetic constants.
// No dependencies.
package idte_pkg;

  localparam int FracDigits = 9;
  localparam int OutDataW   = 72;

  localparam logic [13:0] LimYear  = 14'd9999;
  localparam logic [13:0] LimField = 14'd99;

  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam int DayBias = 719591;

  typedef enum logic [3:0] {
    PH_ERROR    = 4'd0,
    PH_YEAR     = 4'd1,
    PH_MONTH    = 4'd2,
    PH_DAY      = 4'd3,
    PH_HOUR     = 4'd4,
    PH_MINUTE   = 4'd5,
    PH_SECOND   = 4'd6,
    PH_FRAC     = 4'd7,
    PH_DONE     = 4'd8,
    PH_ZONE     = 4'd9,
    PH_ZONE_MIN = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARSE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CS_PARSE,
    CS_CALC0,
    CS_CALC1,
    CS_CALC2,
    CS_CALC3,
    CS_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic parse;
    logic load;
  } cmd_t;

  function automatic logic [16:0] dec_step(logic [13:0] acc, logic [3:0] dig);
    return 17'(acc) * 17'd10 + 17'(dig);
  endfunction

  function automatic logic [29:0] pow10_pad(logic [3:0] count);
    logic [29:0] p;
    case (count)
      4'd0:    p = 30'd1000000000;
      4'd1:    p = 30'd100000000;
      4'd2:    p = 30'd10000000;
      4'd3:    p = 30'd1000000;
      4'd4:    p = 30'd100000;
      4'd5:    p = 30'd10000;
      4'd6:    p = 30'd1000;
      4'd7:    p = 30'd100;
      4'd8:    p = 30'd10;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/idte_ctrl.sv
// Sequencer for the date-time converter: handshakes and calculation steps.
// Depends on idte_pkg.
module idte_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  input  logic            s_axis_tlast_i,
  output logic            s_axis_tready_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output idte_pkg::cmd_t  cmd_o
);
  import idte_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        s_beat;
  logic        out_free;

  assign s_beat   = s_axis_tvalid_i & (state_q == CS_PARSE);
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_PARSE: begin
        if (s_beat && s_axis_tlast_i) state_d = CS_CALC0;
      end
      CS_CALC0: state_d = CS_CALC1;
      CS_CALC1: state_d = CS_CALC2;
      CS_CALC2: state_d = CS_CALC3;
      CS_CALC3: state_d = CS_LOAD;
      CS_LOAD: begin
        if (out_free) state_d = CS_PARSE;
      end
      default: state_d = CS_PARSE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == CS_PARSE);
    cmd_o.parse     = s_beat;
    cmd_o.load      = (state_q == CS_LOAD) && out_free;
    m_axis_tvalid_o = out_valid_q;
    out_valid_d     = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result loaded over an untaken beat");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_beat && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input not stalled after last beat");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> m_axis_tvalid_o)
    else $error("load did not raise valid");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd_o.load))
    else $error("valid rose without a load");

endmodule

// File: hdl/idte_dp.sv
// Datapath for the date-time converter: character parser, field
// accumulators, epoch arithmetic pipeline and result register.
// Depends on idte_pkg.
module idte_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  idte_pkg::cmd_t        cmd_i,
  input  logic [7:0]            char_i,
  output logic [40:0]           epoch_o,
  output logic [29:0]           nanos_o,
  output idte_pkg::status_e     status_o
);
  import idte_pkg::*;

  phase_e       phase_q, phase_d;
  logic [13:0]  year_q, year_d;
  logic [6:0]   month_q, month_d;
  logic [6:0]   day_q, day_d;
  logic [6:0]   hour_q, hour_d;
  logic [6:0]   minute_q, minute_d;
  logic [6:0]   second_q, second_d;
  logic [29:0]  frac_q, frac_d;
  logic [3:0]   count_q, count_d;
  logic [13:0]  zone_q, zone_d;
  logic         zneg_q, zneg_d;
  status_e      err_q, err_d;

  logic         is_dig;
  logic [3:0]   dig;
  logic [13:0]  cur_acc;
  logic [13:0]  cur_lim;
  logic [16:0]  nxt;
  logic         ovf;
  logic         take;
  logic         bad;

  logic signed [14:0] y_q, y_d;
  logic [6:0]         m_q, m_d;
  logic [19:0]        v_q, v_d;
  logic [6:0]         zq_q, zq_d;
  logic [27:0]        zq_prod;
  logic signed [7:0]  a_q, a_d;
  logic [27:0]        a_prod;
  logic [6:0]         w_q, w_d;
  logic [39:0]        w_prod;
  logic [6:0]         zr_q, zr_d;
  logic [13:0]        zr_diff;
  logic signed [22:0] t1_q, t1_d;
  logic signed [25:0] t1_prod;
  logic [29:0]        nano_q, nano_d;
  logic [59:0]        nano_prod;
  logic signed [7:0]  a_div4;
  logic signed [23:0] days_q, days_d;
  logic [19:0]        zs_mag;
  logic signed [19:0] zs_q, zs_d;
  logic [40:0]        total_q, total_d;

  logic [40:0]        epoch_q;
  logic [29:0]        nanos_q;
  status_e            status_q;

  assign is_dig = char_i inside {[ChZero:ChNine]};
  assign dig    = char_i[3:0];

  always_comb begin
    case (phase_q)
      PH_YEAR:                 begin cur_acc = year_q;          cur_lim = LimYear;  end
      PH_MONTH:                begin cur_acc = 14'(month_q);    cur_lim = LimField; end
      PH_DAY:                  begin cur_acc = 14'(day_q);      cur_lim = LimField; end
      PH_HOUR:                 begin cur_acc = 14'(hour_q);     cur_lim = LimField; end
      PH_MINUTE:               begin cur_acc = 14'(minute_q);   cur_lim = LimField; end
      PH_SECOND:               begin cur_acc = 14'(second_q);   cur_lim = LimField; end
      PH_ZONE, PH_ZONE_MIN:    begin cur_acc = zone_q;          cur_lim = LimYear;  end
      default:                 begin cur_acc = '0;              cur_lim = LimField; end
    endcase
    nxt = dec_step(cur_acc, dig);
    ovf = nxt > 17'(cur_lim);
  end

  always_comb begin
    phase_d  = phase_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    frac_d   = frac_q;
    count_d  = count_q;
    zone_d   = zone_q;
    zneg_d   = zneg_q;
    err_d    = err_q;
    take     = 1'b0;
    bad      = 1'b0;
    if (cmd_i.load) begin
      phase_d  = PH_YEAR;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      frac_d   = '0;
      count_d  = '0;
      zone_d   = '0;
      zneg_d   = 1'b0;
      err_d    = ST_OK;
    end else if (cmd_i.parse) begin
      case (phase_q)
        PH_YEAR: begin
          if (char_i == ChDash) phase_d = PH_MONTH;
          else if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        PH_MONTH: begin
          if (char_i == ChDash) phase_d = PH_DAY;
          else if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        PH_DAY: begin
          if (char_i == ChT || char_i == ChSpace) phase_d = PH_HOUR;
          else if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        PH_HOUR: begin
          if (char_i == ChColon) phase_d = PH_MINUTE;
          else if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        PH_MINUTE: begin
          if (char_i == ChColon) phase_d = PH_SECOND;
          else if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        PH_SECOND: begin
          if (char_i == ChDot) phase_d = PH_FRAC;
          else if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        PH_FRAC: begin
          if (char_i == ChZ) begin
            phase_d = PH_DONE;
          end else if (char_i == ChPlus) begin
            phase_d = PH_ZONE;
          end else if (char_i == ChDash) begin
            phase_d = PH_ZONE;
            zneg_d  = 1'b1;
          end else if (is_dig && (count_q < 4'(FracDigits))) begin
            frac_d  = frac_q * 30'd10 + 30'(dig);
            count_d = count_q + 4'd1;
          end
        end
        PH_ZONE: begin
          if (char_i == ChColon) phase_d = PH_ZONE_MIN;
          else if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        PH_ZONE_MIN: begin
          if (is_dig) take = 1'b1;
          else bad = 1'b1;
        end
        default: ;
      endcase
      if (take) begin
        if (ovf) begin
          if (err_q == ST_OK) err_d = ST_OVERFLOW;
        end else begin
          case (phase_q)
            PH_YEAR:              year_d   = nxt[13:0];
            PH_MONTH:             month_d  = nxt[6:0];
            PH_DAY:               day_d    = nxt[6:0];
            PH_HOUR:              hour_d   = nxt[6:0];
            PH_MINUTE:            minute_d = nxt[6:0];
            PH_SECOND:            second_d = nxt[6:0];
            PH_ZONE, PH_ZONE_MIN: zone_d   = nxt[13:0];
            default: ;
          endcase
        end
      end
      if (bad) begin
        if (err_q == ST_OK) err_d = ST_PARSE;
        phase_d = PH_ERROR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_YEAR;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
      count_q  <= '0;
      zone_q   <= '0;
      zneg_q   <= 1'b0;
      err_q    <= ST_OK;
    end else begin
      phase_q  <= phase_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      frac_q   <= frac_d;
      count_q  <= count_d;
      zone_q   <= zone_d;
      zneg_q   <= zneg_d;
      err_q    <= err_d;
    end
  end

  // step 0: shift Jan/Feb to the previous year, zone hours
  always_comb begin
    y_d     = $signed({1'b0, year_q}) - ((month_q < 7'd3) ? 15'sd1 : 15'sd0);
    m_d     = (month_q < 7'd3) ? 7'(month_q + 7'd13) : 7'(month_q + 7'd1);
    v_d     = 20'(m_d) * 20'd6001;
    zq_prod = 28'(zone_q) * 28'd10486;
    zq_d    = zq_prod[26:20];
  end

  // step 1: century, month days, year days, zone minutes, nanoseconds
  always_comb begin
    a_prod    = 28'(y_q[13:0]) * 28'd10486;
    a_d       = y_q[14] ? -8'sd1 : $signed({1'b0, a_prod[26:20]});
    w_prod    = 40'(v_q) * 40'd858994;
    w_d       = w_prod[39:33];
    zr_diff   = zone_q - 14'(zq_q) * 14'd100;
    zr_d      = zr_diff[6:0];
    t1_prod   = 26'(y_q) * 26'sd1461;
    t1_d      = t1_prod[24:2];
    nano_prod = 60'(frac_q) * 60'(pow10_pad(count_q));
    nano_d    = nano_prod[29:0];
  end

  // step 2: day number, zone offset in seconds
  always_comb begin
    a_div4 = a_q >>> 2;
    days_d = 24'(t1_q) + 24'(m_q) * 24'd30 + 24'(w_q) + 24'(day_q)
           - 24'(DayBias) - 24'(a_q) + 24'(a_div4);
    zs_mag = 20'(zq_q) * 20'd3600 + 20'(zr_q) * 20'd60;
    zs_d   = zneg_q ? -$signed(zs_mag) : $signed(zs_mag);
  end

  // step 3: total seconds
  always_comb begin
    total_d = 41'(days_q) * 41'd86400 + 41'(hour_q) * 41'd3600
            + 41'(minute_q) * 41'd60 + 41'(second_q) - 41'(zs_q);
  end

  always_ff @(posedge clk_i) begin
    y_q     <= y_d;
    m_q     <= m_d;
    v_q     <= v_d;
    zq_q    <= zq_d;
    a_q     <= a_d;
    w_q     <= w_d;
    zr_q    <= zr_d;
    t1_q    <= t1_d;
    nano_q  <= nano_d;
    days_q  <= days_d;
    zs_q    <= zs_d;
    total_q <= total_d;
    if (cmd_i.load) begin
      status_q <= err_q;
      if (err_q == ST_OK) begin
        epoch_q <= total_q;
        nanos_q <= nano_q;
      end else begin
        epoch_q <= '0;
        nanos_q <= '0;
      end
    end
  end

  assign epoch_o  = epoch_q;
  assign nanos_o  = nanos_q;
  assign status_o = status_q;

endmodule

// File: hdl/iso_datetime_to_epoch.sv
// ISO 8601 date-time string to Unix seconds, one character per beat, one cycle each.
// After the last beat the input stalls: four arithmetic steps, then the result
// loads into the output register, later while a result waits.
// Reset (async, active low) clears output valid, not the result register, and
// returns the parser to the year field with all accumulators and the status cleared.
module iso_datetime_to_epoch (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [idte_pkg::OutDataW-1:0] m_axis_tdata_o, // [40:0] epoch_seconds, [70:41] nanoseconds
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import idte_pkg::*;

  cmd_t        cmd;
  logic [40:0] epoch;
  logic [29:0] nanos;
  status_e     status;

  idte_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  idte_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .char_i   (s_axis_tdata_i),
    .epoch_o  (epoch),
    .nanos_o  (nanos),
    .status_o (status)
  );

  assign m_axis_tdata_o = {1'b0, nanos, epoch};
  assign m_axis_tuser_o = status;

endmodule

// File: tb/tb_iso_datetime_to_epoch.sv
// Self-checking testbench for iso_datetime_to_epoch: feeds date-time strings one
// character per beat and checks every result against a built-in predictor.
// Depends on idte_pkg and the iso_datetime_to_epoch RTL only.
module tb_iso_datetime_to_epoch;
  import idte_pkg::*;

  localparam int ItemTarget  = 1150;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 40;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic [7:0]          in_char   = 8'd0;
  logic                in_last   = 1'b0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [OutDataW-1:0] out_data;
  logic [1:0]          out_status;

  iso_datetime_to_epoch dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_char),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_status)
  );

  class epoch_scoreboard;
    typedef struct packed {
      logic [40:0] secs;
      logic [29:0] nanos;
      status_e     status;
    } epoch_t;

    epoch_t  expected_q[$];
    int      errors;
    phase_e  phase;
    int      year, month, day, hour, minute, second, frac, frac_cnt, zone;
    bit      zone_neg;
    status_e status;

    function new();
      errors = 0;
      clear_fields();
    endfunction

    function void clear_fields();
      phase = PH_YEAR;
      year = 0; month = 0; day = 0;
      hour = 0; minute = 0; second = 0;
      frac = 0; frac_cnt = 0; zone = 0;
      zone_neg = 1'b0;
      status = ST_OK;
    endfunction

    function void raise(status_e code);
      if (status == ST_OK) status = code;
    endfunction

    function int add_digit(int acc, int limit, int d);
      if (acc * 10 + d > limit) begin
        raise(ST_OVERFLOW);
        return acc;
      end
      return acc * 10 + d;
    endfunction

    function longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q -= 1;
      return q;
    endfunction

    function longint epoch_seconds();
      longint y, m, a, days, offs;
      y = year;
      m = month;
      if (m < 3) begin
        y -= 1;
        m += 13;
      end else begin
        m += 1;
      end
      a = floor_quot(y, 100);
      days = floor_quot(1461 * y, 4) + (306001 * m) / 10000 + longint'(day)
           - longint'(DayBias) - a + floor_quot(a, 4);
      offs = longint'(zone / 100) * 3600 + longint'(zone % 100) * 60;
      if (zone_neg) offs = -offs;
      return days * 86400 + longint'(hour) * 3600 + longint'(minute) * 60
           + longint'(second) - offs;
    endfunction

    // returns 1 when the character is a live item or the last of a string, not one dropped after Z or an error
    function bit note_char(logic [7:0] ch, logic last);
      bit     ch_num, bad, live;
      int     d;
      longint ns;
      epoch_t res;
      ch_num = ch >= ChZero && ch <= ChNine;
      d = ch_num ? int'(ch - ChZero) : 0;
      bad = 1'b0;
      live = phase != PH_DONE && phase != PH_ERROR;
      case (phase)
        PH_YEAR: begin
          if (ch == ChDash) phase = PH_MONTH;
          else if (ch_num) year = add_digit(year, int'(LimYear), d);
          else bad = 1'b1;
        end
        PH_MONTH: begin
          if (ch == ChDash) phase = PH_DAY;
          else if (ch_num) month = add_digit(month, int'(LimField), d);
          else bad = 1'b1;
        end
        PH_DAY: begin
          if (ch == ChT || ch == ChSpace) phase = PH_HOUR;
          else if (ch_num) day = add_digit(day, int'(LimField), d);
          else bad = 1'b1;
        end
        PH_HOUR: begin
          if (ch == ChColon) phase = PH_MINUTE;
          else if (ch_num) hour = add_digit(hour, int'(LimField), d);
          else bad = 1'b1;
        end
        PH_MINUTE: begin
          if (ch == ChColon) phase = PH_SECOND;
          else if (ch_num) minute = add_digit(minute, int'(LimField), d);
          else bad = 1'b1;
        end
        PH_SECOND: begin
          if (ch == ChDot) phase = PH_FRAC;
          else if (ch_num) second = add_digit(second, int'(LimField), d);
          else bad = 1'b1;
        end
        PH_FRAC: begin
          if (ch == ChZ) phase = PH_DONE;
          else if (ch == ChPlus) phase = PH_ZONE;
          else if (ch == ChDash) begin
            phase = PH_ZONE;
            zone_neg = 1'b1;
          end else if (ch_num && frac_cnt < FracDigits) begin
            frac = frac * 10 + d;
            frac_cnt++;
          end
        end
        PH_ZONE: begin
          if (ch == ChColon) phase = PH_ZONE_MIN;
          else if (ch_num) zone = add_digit(zone, int'(LimYear), d);
          else bad = 1'b1;
        end
        PH_ZONE_MIN: begin
          if (ch_num) zone = add_digit(zone, int'(LimYear), d);
          else bad = 1'b1;
        end
        default: begin
        end
      endcase
      if (bad) begin
        raise(ST_PARSE);
        phase = PH_ERROR;
      end
      if (last) begin
        res.secs = '0;
        res.nanos = '0;
        res.status = status;
        if (status == ST_OK) begin
          ns = frac;
          for (int i = frac_cnt; i < 9; i++) ns *= 10;
          res.secs = 41'(epoch_seconds());
          res.nanos = 30'(ns);
        end
        expected_q.push_back(res);
        clear_fields();
      end
      return live || last;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [40:0] secs, logic [29:0] nanos, logic [1:0] st);
      epoch_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: secs=%0d ns=%0d status=%0d",
                         $signed(secs), nanos, st));
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.secs !== secs || exp_r.nanos !== nanos || exp_r.status !== st)
        report($sformatf("mismatch: secs exp %0d got %0d, ns exp %0d got %0d, status exp %0d got %0d",
                         $signed(exp_r.secs), $signed(secs), exp_r.nanos, nanos,
                         exp_r.status, st));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  epoch_scoreboard sb = new();
  logic [7:0]      text[$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              stall_req = 1'b0;
  int              items_done = 0;
  int              cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random backpressure plus one long hold-off while the sender keeps going
  initial begin
    int hold_count;
    bit hold_done;
    hold_count = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(out_data[40:0], out_data[70:41], out_status);
      if (stall_req && !hold_done) begin
        hold_count++;
        if (hold_count >= HoldCycles) hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    if (sb.note_char(c, last)) items_done++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic put_field(int v, int width);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < $urandom_range(1, width + 1)) s = {"0", s};
    put_str(s);
    if ($urandom_range(99) < 3)
      repeat ($urandom_range(1, 2)) text.push_back(ChZero + 8'($urandom_range(9)));
  endtask

  task automatic make_datetime();
    int         n, cut;
    logic [7:0] c;
    text.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
      return;
    end
    put_field(($urandom_range(99) < 60) ? $urandom_range(1900, 2100)
                                        : $urandom_range(0, 9999), 4);
    text.push_back(ChDash);
    put_field(($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(0, 99), 2);
    text.push_back(ChDash);
    put_field(($urandom_range(99) < 80) ? $urandom_range(1, 31) : $urandom_range(0, 99), 2);
    text.push_back($urandom_range(1) ? ChT : ChSpace);
    put_field(($urandom_range(99) < 80) ? $urandom_range(0, 23) : $urandom_range(0, 99), 2);
    text.push_back(ChColon);
    put_field(($urandom_range(99) < 80) ? $urandom_range(0, 59) : $urandom_range(0, 99), 2);
    text.push_back(ChColon);
    put_field(($urandom_range(99) < 80) ? $urandom_range(0, 59) : $urandom_range(0, 99), 2);
    if ($urandom_range(9) != 0) begin
      text.push_back(ChDot);
      n = $urandom_range(0, 12);
      repeat (n) begin
        if ($urandom_range(99) < 5) begin
          c = 8'($urandom_range(255));
          if ((c >= ChZero && c <= ChNine) || c == ChZ || c == ChPlus || c == ChDash)
            c = ChT;
          text.push_back(c);
        end
        text.push_back(ChZero + 8'($urandom_range(9)));
      end
      case ($urandom_range(4))
        0: begin
        end
        1: begin
          text.push_back(ChZ);
          repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(255)));
        end
        2, 3: begin
          text.push_back($urandom_range(1) ? ChPlus : ChDash);
          put_field($urandom_range(0, 23), 1);
          if ($urandom_range(1)) text.push_back(ChColon);
          put_field($urandom_range(0, 59), 1);
        end
        default: begin
          text.push_back($urandom_range(1) ? ChPlus : ChDash);
          repeat ($urandom_range(0, 5)) text.push_back(ChZero + 8'($urandom_range(9)));
        end
      endcase
    end
    n = $urandom_range(99);
    if (n < 12) begin
      text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(255));
    end else if (n < 22) begin
      cut = $urandom_range(1, text.size());
      while (text.size() > cut) void'(text.pop_back());
    end
  endtask

  task automatic run_random(int upto);
    while (items_done < upto) begin
      make_datetime();
      send_text();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 56;
    text.delete();
    text.push_back(8'hFF);
    send_text();
    text.delete();
    put_str("99999");
    send_text();
    text.delete();
    put_str("0-0-0T0:0:0.1234567890Z~");
    send_text();
    run_random(ItemTarget / 3);

    send_idle_pct = 56;
    recv_idle_pct = 21;
    run_random(2 * ItemTarget / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req = 1'b1;
    run_random(ItemTarget);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/idte_pkg.sv
hdl/idte_ctrl.sv
hdl/idte_dp.sv
hdl/iso_datetime_to_epoch.sv
tb/tb_iso_datetime_to_epoch.sv
